>>> rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants of the prescaled match timer
// Holds the operation codes, the register word map and the beat structures
// that pass between the top level and the timer core.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

    // Number of match channels that have a stored match value (1 to 4).
    localparam int MATCH_CHANNELS = 4;
    localparam int MATCH_IDX_W    = (MATCH_CHANNELS > 1) ? $clog2(MATCH_CHANNELS) : 1;

    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 32;
    localparam int CAPTURE_W = 6;
    localparam int MODE_W    = 4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Register word offsets.
    localparam logic [ADDR_W-1:0] WORD_CONTROL         = 12'd1;
    localparam logic [ADDR_W-1:0] WORD_COUNT           = 12'd2;
    localparam logic [ADDR_W-1:0] WORD_PRESCALE_LIMIT  = 12'd3;
    localparam logic [ADDR_W-1:0] WORD_PRESCALE_COUNT  = 12'd4;
    localparam logic [ADDR_W-1:0] WORD_MATCH_CONTROL   = 12'd5;
    localparam logic [ADDR_W-1:0] WORD_MATCH_BASE      = 12'd6;
    localparam logic [ADDR_W-1:0] WORD_CAPTURE_CONTROL = 12'd10;
    localparam logic [ADDR_W-1:0] WORD_EXT_MATCH       = 12'd15;
    localparam logic [ADDR_W-1:0] WORD_MODE            = 12'd28;

    // Control register bits and the enable-only arming pattern.
    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_RESET_BIT  = 1;
    localparam logic [1:0] CTRL_ARM_PATTERN = 2'b01;

    // Per channel match control bits, relative to bit 3c.
    localparam int MCR_STRIDE    = 3;
    localparam int MCR_IRQ_BIT   = 0;
    localparam int MCR_RESET_BIT = 1;
    localparam int MCR_STOP_BIT  = 2;

    typedef struct packed {
        op_t               operation;
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pulse;
        logic              access_error;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/pmt_core.sv
// ----------------------------------------------------------------------------
// pmt_core: timer state and beat processing
// Holds all timer registers, decodes one request beat and, when told to
// process it, updates the state; the response is produced combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  wire pmt_pkg::req_t req,
    output pmt_pkg::rsp_t      rsp
);

    localparam int Chans = pmt_pkg::MATCH_CHANNELS;
    localparam int IdxW  = pmt_pkg::MATCH_IDX_W;
    localparam int DataW = pmt_pkg::DATA_W;
    localparam int CapW  = pmt_pkg::CAPTURE_W;
    localparam int ModeW = pmt_pkg::MODE_W;
    localparam logic [pmt_pkg::ADDR_W-1:0] MatchEnd =
        pmt_pkg::WORD_MATCH_BASE + pmt_pkg::ADDR_W'(Chans);

    logic [DataW-1:0] control_reg, control_next;
    logic [DataW-1:0] count_value_reg, count_value_next;
    logic [DataW-1:0] prescale_limit_reg, prescale_limit_next;
    logic [DataW-1:0] prescale_count_reg, prescale_count_next;
    logic [DataW-1:0] match_control_reg, match_control_next;
    logic [DataW-1:0] match_values_reg [Chans];
    logic [CapW-1:0]  capture_control_reg, capture_control_next;
    logic [ModeW-1:0] mode_control_reg, mode_control_next;
    logic             armed_reg, armed_next;

    logic [IdxW-1:0]            match_idx;
    logic                       is_match_word;
    logic                       match_we;

    logic [DataW-1:0] prescale_inc;
    logic [DataW-1:0] count_inc;
    logic             hit;
    logic [2:0]       hit_bits;

    assign match_idx     = IdxW'(req.word_address - pmt_pkg::WORD_MATCH_BASE);
    assign is_match_word = (req.word_address >= pmt_pkg::WORD_MATCH_BASE) &&
                           (req.word_address < MatchEnd);

    assign prescale_inc = prescale_count_reg + 1'b1;
    assign count_inc    = count_value_reg + 1'b1;

    // First matching channel wins: walk downward so the lowest index is kept.
    always_comb begin
        hit      = 1'b0;
        hit_bits = '0;
        for (int c = Chans - 1; c >= 0; c--) begin
            if (count_inc == match_values_reg[c]) begin
                hit      = 1'b1;
                hit_bits = match_control_reg[pmt_pkg::MCR_STRIDE*c +: 3];
            end
        end
    end

    always_comb begin
        control_next         = control_reg;
        count_value_next     = count_value_reg;
        prescale_limit_next  = prescale_limit_reg;
        prescale_count_next  = prescale_count_reg;
        match_control_next   = match_control_reg;
        capture_control_next = capture_control_reg;
        mode_control_next    = mode_control_reg;
        armed_next           = armed_reg;
        match_we             = 1'b0;
        rsp                  = '0;

        case (req.operation)
            pmt_pkg::OP_TICK: begin
                if (armed_reg && control_reg[pmt_pkg::CTRL_ENABLE_BIT]) begin
                    if (control_reg[pmt_pkg::CTRL_RESET_BIT]) begin
                        count_value_next    = '0;
                        prescale_count_next = '0;
                    end else if (mode_control_reg[1:0] == 2'b00) begin
                        if (prescale_inc <= prescale_limit_reg) begin
                            prescale_count_next = prescale_inc;
                        end else begin
                            prescale_count_next = '0;
                            count_value_next    = count_inc;
                            if (hit) begin
                                if (hit_bits[pmt_pkg::MCR_RESET_BIT]) begin
                                    count_value_next = '0;
                                end
                                if (hit_bits[pmt_pkg::MCR_STOP_BIT]) begin
                                    armed_next = 1'b0;
                                end
                                rsp.irq_pulse = hit_bits[pmt_pkg::MCR_IRQ_BIT];
                            end
                        end
                    end
                end
            end
            pmt_pkg::OP_READ: begin
                if (is_match_word) begin
                    rsp.read_data = match_values_reg[match_idx];
                end else begin
                    unique case (req.word_address)
                        pmt_pkg::WORD_CONTROL:         rsp.read_data = control_reg;
                        pmt_pkg::WORD_COUNT:           rsp.read_data = count_value_reg;
                        pmt_pkg::WORD_PRESCALE_LIMIT:  rsp.read_data = prescale_limit_reg;
                        pmt_pkg::WORD_PRESCALE_COUNT:  rsp.read_data = prescale_count_reg;
                        pmt_pkg::WORD_MATCH_CONTROL:   rsp.read_data = match_control_reg;
                        pmt_pkg::WORD_CAPTURE_CONTROL: rsp.read_data = DataW'(capture_control_reg);
                        pmt_pkg::WORD_MODE:            rsp.read_data = DataW'(mode_control_reg);
                        default:                       rsp.read_data = '0;
                    endcase
                end
            end
            pmt_pkg::OP_WRITE: begin
                if (is_match_word) begin
                    match_we = 1'b1;
                end else begin
                    unique case (req.word_address)
                        pmt_pkg::WORD_CONTROL: begin
                            control_next = req.write_data;
                            if (req.write_data[1:0] == pmt_pkg::CTRL_ARM_PATTERN) begin
                                armed_next = 1'b1;
                            end
                        end
                        pmt_pkg::WORD_COUNT:          count_value_next    = req.write_data;
                        pmt_pkg::WORD_PRESCALE_LIMIT: prescale_limit_next = req.write_data;
                        pmt_pkg::WORD_PRESCALE_COUNT: prescale_count_next = req.write_data;
                        pmt_pkg::WORD_MATCH_CONTROL:  match_control_next  = req.write_data;
                        pmt_pkg::WORD_CAPTURE_CONTROL:
                            capture_control_next = capture_control_reg | req.write_data[CapW-1:0];
                        pmt_pkg::WORD_EXT_MATCH:      rsp.access_error = 1'b1;
                        pmt_pkg::WORD_MODE:
                            mode_control_next = mode_control_reg | req.write_data[ModeW-1:0];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_reg         <= '0;
            count_value_reg     <= '0;
            prescale_limit_reg  <= '0;
            prescale_count_reg  <= '0;
            match_control_reg   <= '0;
            capture_control_reg <= '0;
            mode_control_reg    <= '0;
            armed_reg           <= 1'b0;
            for (int c = 0; c < Chans; c++) begin
                match_values_reg[c] <= '0;
            end
        end else if (fire) begin
            control_reg         <= control_next;
            count_value_reg     <= count_value_next;
            prescale_limit_reg  <= prescale_limit_next;
            prescale_count_reg  <= prescale_count_next;
            match_control_reg   <= match_control_next;
            capture_control_reg <= capture_control_next;
            mode_control_reg    <= mode_control_next;
            armed_reg           <= armed_next;
            if (match_we) begin
                match_values_reg[match_idx] <= req.write_data;
            end
        end
    end

`ifndef SYNTH
    // The timer only disarms itself on a processed tick.
    a_disarm_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(armed_reg) |->
            $past(fire) && $past(req.operation) == pmt_pkg::OP_TICK)
        else $error("timer disarmed without a tick");

    // An interrupt pulse needs an armed, enabled timer and a tick.
    a_irq_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && rsp.irq_pulse |->
            req.operation == pmt_pkg::OP_TICK && armed_reg &&
            control_reg[pmt_pkg::CTRL_ENABLE_BIT])
        else $error("interrupt pulse without an armed tick");

    // A tick on a disarmed timer leaves both counters alone.
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && req.operation == pmt_pkg::OP_TICK && !armed_reg |=>
            $stable(count_value_reg) && $stable(prescale_count_reg))
        else $error("counters moved while disarmed");

    // Only a write to the external match word is refused.
    a_error_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && rsp.access_error |->
            req.operation == pmt_pkg::OP_WRITE &&
            req.word_address == pmt_pkg::WORD_EXT_MATCH)
        else $error("access error on a legal beat");
`endif

endmodule

`default_nettype wire

>>> rtl/prescaled_match_timer.sv
// Order: a beat accepted into the input register is processed once the output
// register is free, and its result is registered there, raising m_valid.
// Throughput: one beat per cycle while m_ready does not hold the output; the
// input register and the output register form a two-stage pipeline.
// Reset: aresetn is synchronous and active low; it empties both stages and
// clears every timer register, leaving the timer disarmed.
// ----------------------------------------------------------------------------
// prescaled_match_timer: prescaled timer with four match channels
// Accepts tick, register read and register write beats and returns one
// result beat for each, carrying read data, an interrupt pulse and an error.
// ----------------------------------------------------------------------------
`default_nettype none

module prescaled_match_timer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [11:0] s_word_address,
    input  wire logic [31:0] s_write_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_data,
    output logic             m_irq_pulse,
    output logic             m_access_error
);

    // The input register holds one request beat. The beat is processed in
    // the cycle in which the output register can take its result, and that
    // is the same cycle in which the timer state is updated. A new beat may
    // enter the input register whenever the beat in it moves on, so a
    // result waiting on m_ready does not stop the input while the input
    // register is empty.
    logic          in_valid_reg;
    pmt_pkg::req_t in_reg;
    logic          out_valid_reg;
    pmt_pkg::rsp_t out_reg;
    pmt_pkg::rsp_t core_rsp;

    logic out_free;
    logic fire;

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // The payload needs no reset; it is only looked at when its valid is set.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.operation    <= pmt_pkg::op_t'(s_operation);
            in_reg.word_address <= s_word_address;
            in_reg.write_data   <= s_write_data;
        end
    end

    pmt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_reg),
        .rsp     (core_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= core_rsp;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_reg.read_data;
    assign m_irq_pulse    = out_reg.irq_pulse;
    assign m_access_error = out_reg.access_error;

`ifndef SYNTH
    // A result beat held back by the sink must not be overwritten.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result beat lost while stalled");

    // The core only processes a beat that is actually present.
    a_fire_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> in_valid_reg && out_free)
        else $error("processing without a request beat");

    // Each processed beat produces exactly one result beat on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed beat produced no result");
`endif

endmodule

`default_nettype wire
